@@ rtl/audio_energy_beat_detector_unit_defines.svh @@
// Assertion macros shared by the beat detector RTL.
// No dependencies; included by the modules that carry concurrent checks.
`ifndef AUDIO_ENERGY_BEAT_DETECTOR_UNIT_DEFINES_SVH
`define AUDIO_ENERGY_BEAT_DETECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define AEBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aebd same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define AEBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aebd next-cycle check failed");
`else
`define AEBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define AEBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/aebd_pkg.sv @@
// Shared widths, register codes, pipeline structs and color table for the beat detector.
// No dependencies; imported by every other RTL file but the assertion macro header.
package aebd_pkg;

    localparam int ENERGY_W   = 17;
    localparam int RANDOM_W   = 15;
    localparam int ENTRY_W    = 12;
    localparam int TOTAL_W    = 18;
    localparam int SIL_W      = 18;
    localparam int SAT_W      = 17;
    localparam int LEVEL_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [ENTRY_W-1:0] ENTRY_MAX = 12'hFFF;

    localparam logic [SIL_W-1:0]   SIL_RESET  = 18'd350;
    localparam logic [SAT_W-1:0]   SAT_RESET  = 17'd97090;
    localparam logic [LEVEL_W-1:0] FULL_RESET = 8'd255;

    // floor(x / 10) for an 18-bit x: (x * 419431) >> 22
    localparam int                DIV10_W     = 19;
    localparam logic [DIV10_W-1:0] DIV10_RECIP = 19'd419431;
    localparam int                DIV10_SHIFT = 22;
    localparam int                Q10_W       = 15;
    localparam int                LIMIT_W     = 19;

    // floor(x / 7) for a 15-bit x: (x * 37450) >> 18
    localparam int                DIV7_W     = 16;
    localparam logic [DIV7_W-1:0] DIV7_RECIP = 16'd37450;
    localparam int                DIV7_SHIFT = 18;
    localparam int                Q7_W       = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SILENCE_THRESHOLD = 2'd0,
        CFG_SATURATION_LEVEL  = 2'd1,
        CFG_LED_FULL_SCALE    = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        COLOR_WHITE   = 3'd0,
        COLOR_RED     = 3'd1,
        COLOR_MAGENTA = 3'd2,
        COLOR_BLUE    = 3'd3,
        COLOR_CYAN    = 3'd4,
        COLOR_GREEN   = 3'd5,
        COLOR_YELLOW  = 3'd6
    } t_color_sel;

    typedef struct packed {
        logic [SIL_W-1:0]   silence_threshold;
        logic [SAT_W-1:0]   saturation_level;
        logic [LEVEL_W-1:0] led_full_scale;
    } t_cfg;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } t_color;

    // Item leaving the history stage: running total already includes this item.
    typedef struct packed {
        logic [ENERGY_W-1:0] energy_sum;
        logic [RANDOM_W-1:0] random_value;
        logic [TOTAL_W-1:0]  total;
        logic                full;
    } t_hist_item;

    // floor(13 * r / 10) for a remainder r below ten
    function automatic logic [3:0] frac13(input logic [3:0] r);
        logic [3:0] v;
        case (r)
            4'd0:    v = 4'd0;
            4'd1:    v = 4'd1;
            4'd2:    v = 4'd2;
            4'd3:    v = 4'd3;
            4'd4:    v = 4'd5;
            4'd5:    v = 4'd6;
            4'd6:    v = 4'd7;
            4'd7:    v = 4'd9;
            4'd8:    v = 4'd10;
            4'd9:    v = 4'd11;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    function automatic t_color pick_color(input t_color_sel sel, input logic [LEVEL_W-1:0] m);
        logic [9:0]  two_m;
        logic [9:0]  three_m;
        logic [20:0] p_two_thirds;
        logic [15:0] p_third;
        logic [7:0]  two_thirds;
        logic [7:0]  third;
        logic [7:0]  three_quarters;
        t_color      c;
        two_m          = {1'b0, m, 1'b0};
        three_m        = 10'(two_m) + 10'(m);
        p_two_thirds   = 21'(two_m) * 21'd683;
        p_third        = 16'(m) * 16'd171;
        two_thirds     = p_two_thirds[18:11];
        third          = {1'b0, p_third[15:9]};
        three_quarters = three_m[9:2];
        c = '0;
        unique case (sel)
            COLOR_WHITE: begin
                c.red   = {1'b0, m[7:1]};
                c.green = {2'b0, m[7:2]};
                c.blue  = {2'b0, m[7:2]};
            end
            COLOR_RED: begin
                c.red = m;
            end
            COLOR_MAGENTA: begin
                c.red  = two_thirds;
                c.blue = third;
            end
            COLOR_BLUE: begin
                c.blue = m;
            end
            COLOR_CYAN: begin
                c.green = {1'b0, m[7:1]};
                c.blue  = {1'b0, m[7:1]};
            end
            COLOR_GREEN: begin
                c.green = m;
            end
            COLOR_YELLOW: begin
                c.red   = three_quarters;
                c.green = {2'b0, m[7:2]};
            end
            default: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

endpackage

@@ rtl/aebd_channels.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on aebd_pkg for field widths.
interface aebd_item_if import aebd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ENERGY_W-1:0] energy_sum;
    logic [RANDOM_W-1:0] random_value;

    modport source (output valid, output energy_sum, output random_value, input ready);
    modport sink   (input valid, input energy_sum, input random_value, output ready);
endinterface

interface aebd_result_if import aebd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               history_ready;
    logic               beat_now;
    logic               light_on;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;

    modport source (output valid, output history_ready, output beat_now, output light_on,
                    output red_level, output green_level, output blue_level, input ready);
    modport sink   (input valid, input history_ready, input beat_now, input light_on,
                    input red_level, input green_level, input blue_level, output ready);
endinterface

@@ rtl/aebd_history.sv @@
// Energy history ring: synchronous memory, per-entry valid bits and running total.
// Depends on aebd_pkg and the assertion macro header.
`include "audio_energy_beat_detector_unit_defines.svh"

module aebd_history import aebd_pkg::*; #(
    parameter int HISTORY_DEPTH = 44
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [ENERGY_W-1:0] i_energy_sum,
    input  logic [RANDOM_W-1:0] i_random_value,
    output logic                o_valid,
    input  logic                i_ready,
    output t_hist_item          o_item
);

    localparam int IDX_W      = $clog2(HISTORY_DEPTH);
    localparam int QUOT_SHIFT = ENERGY_W + $clog2(HISTORY_DEPTH);
    localparam int RECIP_W    = ENERGY_W + 1;
    localparam int PROD_W     = ENERGY_W + RECIP_W;
    localparam longint unsigned QUOT_RECIP =
        ((64'd1 << QUOT_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(HISTORY_DEPTH - 1);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(HISTORY_DEPTH * 4095);

    logic [ENTRY_W-1:0] mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_entry_valid;

    logic [IDX_W-1:0]    r_index;
    logic                r_s1_valid;
    logic [ENERGY_W-1:0] r_s1_sum;
    logic [RANDOM_W-1:0] r_s1_rnd;
    logic [IDX_W-1:0]    r_s1_idx;
    logic [PROD_W-1:0]   r_s1_prod;
    logic [ENTRY_W-1:0]  r_rdata;
    logic                r_rd_valid;
    logic [TOTAL_W-1:0]  r_total;
    logic                r_full;
    logic                r_s2_valid;
    t_hist_item          r_s2_item;

    logic                accept;
    logic                adv1;
    logic [PROD_W-1:0]   quot_shifted;
    logic [ENERGY_W-1:0] quot_raw;
    logic [ENTRY_W-1:0]  quot;
    logic [ENTRY_W-1:0]  old_entry;
    logic [TOTAL_W-1:0]  n_total;
    logic                n_full;

    assign adv1    = r_s1_valid && (!r_s2_valid || i_ready);
    assign o_ready = !r_s1_valid || adv1;
    assign accept  = i_valid && o_ready;

    // divide by the depth with a reciprocal, then clamp into a ring entry
    assign quot_shifted = r_s1_prod >> QUOT_SHIFT;
    assign quot_raw     = quot_shifted[ENERGY_W-1:0];
    assign quot         = (quot_raw > ENERGY_W'(ENTRY_MAX)) ? ENTRY_MAX : quot_raw[ENTRY_W-1:0];
    assign old_entry    = r_rd_valid ? r_rdata : '0;
    assign n_total      = r_total - TOTAL_W'(old_entry) + TOTAL_W'(quot);
    assign n_full       = r_full || (r_s1_idx == LAST_IDX);

    // ring memory: read on accept, write back when the item leaves stage one
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= mem[r_index];
        end
        if (adv1) begin
            mem[r_s1_idx] <= quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sum  <= i_energy_sum;
            r_s1_rnd  <= i_random_value;
            r_s1_idx  <= r_index;
            r_s1_prod <= PROD_W'(i_energy_sum) * PROD_W'(QUOT_RECIP);
        end
        if (adv1) begin
            r_s2_item.energy_sum   <= r_s1_sum;
            r_s2_item.random_value <= r_s1_rnd;
            r_s2_item.total        <= n_total;
            r_s2_item.full         <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index       <= '0;
            r_entry_valid <= '0;
            r_rd_valid    <= 1'b0;
            r_s1_valid    <= 1'b0;
            r_total       <= '0;
            r_full        <= 1'b0;
            r_s2_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_index    <= (r_index == LAST_IDX) ? '0 : r_index + 1'b1;
                r_rd_valid <= r_entry_valid[r_index];
                r_s1_valid <= 1'b1;
            end else if (adv1) begin
                r_s1_valid <= 1'b0;
            end
            if (adv1) begin
                r_entry_valid[r_s1_idx] <= 1'b1;
                r_total                 <= n_total;
                r_full                  <= n_full;
                r_s2_valid              <= 1'b1;
            end else if (r_s2_valid && i_ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_s2_valid;
    assign o_item  = r_s2_item;

    // the write-back of one item never targets the entry read for the next one
    `AEBD_ASSERT_IMPLY(a_rmw_no_overlap, i_clk, i_rst_n, accept && adv1, r_index != r_s1_idx)
    `AEBD_ASSERT_IMPLY(a_total_bound, i_clk, i_rst_n, r_s1_valid, r_total <= TOTAL_MAX)
    `AEBD_ASSERT_NEXT(a_full_sticky, i_clk, i_rst_n, r_full, r_full)

endmodule

@@ rtl/aebd_detect.sv @@
// Beat decision: 1.35x average limit, silence gate, beat hold and color pick.
// Depends on aebd_pkg, the result channel interface and the assertion macro header.
`include "audio_energy_beat_detector_unit_defines.svh"

module aebd_detect import aebd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_hist_item           i_item,
    aebd_result_if.source        o_result
);

    localparam int P10_W = TOTAL_W + DIV10_W;
    localparam int P7_W  = RANDOM_W + DIV7_W;

    // stage A: reciprocal products
    logic             r_a_valid;
    t_hist_item       r_a_item;
    logic [P10_W-1:0] r_a_prod10;
    logic [P7_W-1:0]  r_a_prod7;

    // stage B: quotient by ten, remainder, candidate color
    logic                r_b_valid;
    logic [ENERGY_W-1:0] r_b_sum;
    logic [TOTAL_W-1:0]  r_b_total;
    logic                r_b_full;
    logic [Q10_W-1:0]    r_b_k;
    logic [3:0]          r_b_rem;
    t_color              r_b_color;

    // stage C: result register
    logic   r_c_valid;
    logic   r_c_full;
    logic   r_c_beat;
    logic   r_c_lit;
    t_color r_c_color;

    // decision state
    logic   r_prev;
    logic   r_hold;
    t_color r_color;

    logic               adv_a;
    logic               adv_b;
    logic [Q10_W-1:0]   k;
    logic [TOTAL_W-1:0] ten_k;
    logic [TOTAL_W-1:0] rem_full;
    logic [Q7_W-1:0]    q7;
    logic [RANDOM_W-1:0] seven_q;
    logic [RANDOM_W-1:0] mod7_full;
    logic [LIMIT_W-1:0] limit;
    logic               loud;
    logic               beat;
    logic               lit;
    logic               n_prev;
    logic               n_hold;
    t_color             n_color;

    assign adv_b   = r_b_valid && (!r_c_valid || o_result.ready);
    assign adv_a   = r_a_valid && (!r_b_valid || adv_b);
    assign o_ready = !r_a_valid || adv_a;

    assign k         = r_a_prod10[P10_W-1:DIV10_SHIFT];
    assign ten_k     = TOTAL_W'({k, 3'b000}) + TOTAL_W'({k, 1'b0});
    assign rem_full  = r_a_item.total - ten_k;
    assign q7        = r_a_prod7[P7_W-1:DIV7_SHIFT];
    assign seven_q   = RANDOM_W'({q7, 3'b000}) - RANDOM_W'(q7);
    assign mod7_full = r_a_item.random_value - seven_q;

    // limit = floor(13 * avg / 10) + floor(avg / 20)
    assign limit = LIMIT_W'({r_b_k, 3'b000}) + LIMIT_W'({r_b_k, 2'b00}) + LIMIT_W'(r_b_k)
                 + LIMIT_W'(frac13(r_b_rem)) + LIMIT_W'(r_b_k[Q10_W-1:1]);
    assign loud  = r_b_total > i_cfg.silence_threshold;

    always_comb begin
        beat    = 1'b0;
        lit     = 1'b0;
        n_prev  = r_prev;
        n_hold  = r_hold;
        n_color = r_color;
        if (r_b_full) begin
            if (loud) begin
                beat = (LIMIT_W'(r_b_sum) > limit) || (r_b_sum >= i_cfg.saturation_level);
                if (beat || r_prev) begin
                    // fresh beat: pick a new color; continuing beat or hold keeps it
                    if (!r_prev && !r_hold) begin
                        n_color = r_b_color;
                    end
                    n_hold = !beat && r_prev;
                    n_prev = beat;
                    lit    = 1'b1;
                end else begin
                    n_color = '0;
                    n_prev  = 1'b0;
                    n_hold  = 1'b0;
                end
            end else begin
                n_color = '0;
                n_prev  = 1'b0;
                n_hold  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_a_item   <= i_item;
            r_a_prod10 <= P10_W'(i_item.total) * P10_W'(DIV10_RECIP);
            r_a_prod7  <= P7_W'(i_item.random_value) * P7_W'(DIV7_RECIP);
        end
        if (adv_a) begin
            r_b_sum   <= r_a_item.energy_sum;
            r_b_total <= r_a_item.total;
            r_b_full  <= r_a_item.full;
            r_b_k     <= k;
            r_b_rem   <= rem_full[3:0];
            r_b_color <= pick_color(t_color_sel'(mod7_full[2:0]), i_cfg.led_full_scale);
        end
        if (adv_b) begin
            r_c_full  <= r_b_full;
            r_c_beat  <= beat;
            r_c_lit   <= lit;
            r_c_color <= n_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_prev    <= 1'b0;
            r_hold    <= 1'b0;
            r_color   <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_a_valid <= 1'b1;
            end else if (adv_a) begin
                r_a_valid <= 1'b0;
            end
            if (adv_a) begin
                r_b_valid <= 1'b1;
            end else if (adv_b) begin
                r_b_valid <= 1'b0;
            end
            if (adv_b) begin
                r_c_valid <= 1'b1;
                r_prev    <= n_prev;
                r_hold    <= n_hold;
                r_color   <= n_color;
            end else if (r_c_valid && o_result.ready) begin
                r_c_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid         = r_c_valid;
    assign o_result.history_ready = r_c_full;
    assign o_result.beat_now      = r_c_beat;
    assign o_result.light_on      = r_c_lit;
    assign o_result.red_level     = r_c_color.red;
    assign o_result.green_level   = r_c_color.green;
    assign o_result.blue_level    = r_c_color.blue;

    `AEBD_ASSERT_IMPLY(a_beat_needs_full, i_clk, i_rst_n, r_c_valid && r_c_beat, r_c_full)
    `AEBD_ASSERT_IMPLY(a_dark_when_off, i_clk, i_rst_n, r_c_valid && !r_c_lit, r_c_color == '0)
    `AEBD_ASSERT_IMPLY(a_hold_follows_beat, i_clk, i_rst_n, r_hold, !r_prev)

endmodule

@@ rtl/audio_energy_beat_detector_unit.sv @@
// Top level of the energy beat detector: configuration registers and the two pipeline parts.
// Depends on aebd_pkg, aebd_channels, aebd_history and aebd_detect.
//
// Each input item carries one audio block's energy sum and a random word; each item yields
// exactly one result item. The sum divided by HISTORY_DEPTH (clamped to 12 bits) goes into a
// ring of HISTORY_DEPTH entries held in a synchronous memory, and a running total of the ring
// serves as the average. Once the ring has been filled, an item is a beat when the average is
// above silence_threshold and the energy exceeds 1.35 times the average or reaches
// saturation_level; the light stays on for one more item after a beat, and a fresh beat picks
// one of seven colors by random_value mod 7. Throughput is one item per clock without output
// stalls: the ring memory does one read (at acceptance) and one write-back (as the item
// leaves stage one) per item, and the running total updates combinationally from its
// register. A result passes history registers s1, s2 and detect registers A, B, C before it
// becomes valid, and output backpressure stalls the chain stage by stage while finished
// results wait in their registers. The ring needs no clearing pass after reset: one valid
// bit per entry, cleared by reset, makes unwritten entries read as zero. Configuration
// writes take effect immediately and must only be issued while no items are in flight.
module audio_energy_beat_detector_unit import aebd_pkg::*; #(
    parameter int HISTORY_DEPTH = 44
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    aebd_item_if.sink             i_item,
    aebd_result_if.source         o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg       r_cfg;
    logic       hist_valid;
    logic       hist_ready;
    t_hist_item hist_item;

    // configuration registers; an unknown index leaves everything as is
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.silence_threshold <= SIL_RESET;
            r_cfg.saturation_level  <= SAT_RESET;
            r_cfg.led_full_scale    <= FULL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SILENCE_THRESHOLD: begin
                    r_cfg.silence_threshold <= i_cfg_wdata[SIL_W-1:0];
                end
                CFG_SATURATION_LEVEL: begin
                    r_cfg.saturation_level <= i_cfg_wdata[SAT_W-1:0];
                end
                CFG_LED_FULL_SCALE: begin
                    r_cfg.led_full_scale <= i_cfg_wdata[LEVEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ring read-modify-write and running total
    aebd_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_item.valid),
        .o_ready        (i_item.ready),
        .i_energy_sum   (i_item.energy_sum),
        .i_random_value (i_item.random_value),
        .o_valid        (hist_valid),
        .i_ready        (hist_ready),
        .o_item         (hist_item)
    );

    // threshold arithmetic, beat hold and color selection
    aebd_detect u_detect (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (hist_valid),
        .o_ready  (hist_ready),
        .i_item   (hist_item),
        .o_result (o_result)
    );

endmodule

@@ tb/tb_audio_energy_beat_detector_unit.sv @@
// Self-checking testbench for the audio energy beat detector: directed and random items
// against a built-in predictor. Depends on aebd_pkg, aebd_channels and the detector RTL.
module tb_audio_energy_beat_detector_unit import aebd_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RING_DEPTH       = 44;
    localparam int unsigned ENERGY_MAX       = 2 ** ENERGY_W - 1;
    localparam int unsigned RATIO_NUM        = 13;
    localparam int unsigned RATIO_DEN        = 10;
    localparam int unsigned RATIO_DEN2       = 20;
    localparam int unsigned BASE_ENERGY      = 20000;
    // Results pass the history and detect stage registers; leave some margin on top.
    localparam int          SETTLE_CYCLES    = 8;
    localparam int          DRAIN_TAIL       = 20;
    localparam int          LONG_HOLD_CYCLES = 150;
    localparam int          CYCLE_LIMIT      = 200000;
    localparam int          REPORT_LIMIT     = 10;
    // Index 3 is not a register; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    typedef enum logic [1:0] {
        STEP_ITEM,
        STEP_PAUSE,
        STEP_WRITE
    } step_kind_t;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_LIGHT,
        RX_ALTERNATE,
        RX_HEAVY
    } rx_pattern_t;

    typedef struct {
        step_kind_t              kind;
        logic [ENERGY_W-1:0]     energy;
        logic [RANDOM_W-1:0]     rnd;
        logic [CFG_IDX_W-1:0]    reg_index;
        logic [CFG_DATA_W-1:0]   reg_data;
    } step_t;

    typedef struct packed {
        logic   history_ready;
        logic   beat_now;
        logic   light_on;
        t_color levels;
    } light_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    aebd_item_if   item_ch ();
    aebd_result_if result_ch ();

    audio_energy_beat_detector_unit #(
        .HISTORY_DEPTH(RING_DEPTH)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_item      (item_ch),
        .o_result    (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Pending stimulus: items, pauses that wait for the block to drain, and register writes.
    step_t         stimulus[$];
    light_result_t expected_results[$];

    // Predictor copy of the block's state and registers.
    logic [ENTRY_W-1:0] energy_ring [RING_DEPTH] = '{default: '0};
    logic [TOTAL_W-1:0] ring_total   = '0;
    int                 ring_pos     = 0;
    logic               ring_filled  = 1'b0;
    logic               last_beat    = 1'b0;
    logic               holding      = 1'b0;
    t_color             shown        = '0;
    logic [SIL_W-1:0]   silence_lim  = SIL_RESET;
    logic [SAT_W-1:0]   saturate_lim = SAT_RESET;
    logic [LEVEL_W-1:0] led_scale    = FULL_RESET;

    logic item_taken      = 1'b0;
    int   items_accepted  = 0;
    int   results_checked = 0;
    int   beats_predicted = 0;
    int   fresh_colors    = 0;
    int   quiet_items     = 0;
    int   writes_applied  = 0;
    int   fail_count      = 0;
    int   cycle_count     = 0;

    int   gap_left        = 0;
    int   burst_left      = 1;
    int   settle_left     = 0;
    int   rx_cycle        = 0;
    int   hold_left       = 0;
    int   long_holds      = 0;
    int   hold_trigger    = 300;

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void add_item(input int unsigned energy, input int unsigned rnd);
        step_t s;
        s = '{kind: STEP_ITEM, energy: ENERGY_W'(energy), rnd: RANDOM_W'(rnd),
              reg_index: '0, reg_data: '0};
        stimulus.push_back(s);
    endfunction

    function automatic void add_pause();
        step_t s;
        s = '{kind: STEP_PAUSE, energy: '0, rnd: '0, reg_index: '0, reg_data: '0};
        stimulus.push_back(s);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        step_t s;
        s = '{kind: STEP_WRITE, energy: '0, rnd: '0, reg_index: idx,
              reg_data: CFG_DATA_W'(data)};
        stimulus.push_back(s);
    endfunction

    // Random word whose remainder mod 7 selects the given color, with random upper content.
    function automatic int unsigned color_word(input int unsigned sel);
        return sel + 7 * $urandom_range(0, 4680);
    endfunction

    // Random items around a level that changes every 40 items: mostly steady energy near
    // the level, spikes of 1.5x or more (often in runs, so beats continue and hold), extremes
    // and some fully random values.
    task automatic add_random_items(input int count, input int unsigned level_hi);
        int unsigned level;
        int unsigned lo;
        int unsigned pick;
        int unsigned energy;
        bit          spiking;
        level   = 0;
        spiking = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                level = $urandom_range(0, level_hi);
            end
            pick = $urandom_range(0, 99);
            lo   = level + level / 2;
            if (lo > ENERGY_MAX) begin
                lo = ENERGY_MAX;
            end
            if ((spiking && pick < 40) || pick < 12) begin
                energy  = $urandom_range(lo, ENERGY_MAX);
                spiking = 1'b1;
            end else begin
                spiking = 1'b0;
                if (pick < 16) begin
                    energy = ($urandom_range(0, 1) != 0) ? ENERGY_MAX : 0;
                end else if (pick < 25) begin
                    energy = $urandom_range(0, ENERGY_MAX);
                end else begin
                    energy = level - level / 8 + $urandom_range(0, level / 4);
                    if (energy > ENERGY_MAX) begin
                        energy = ENERGY_MAX;
                    end
                end
            end
            add_item(energy, $urandom);
        end
    endtask

    // Advance the predicted detector by one accepted item and queue its expected result.
    function automatic void predict_light(input logic [ENERGY_W-1:0] energy,
                                          input logic [RANDOM_W-1:0] rnd);
        int unsigned   quot;
        int unsigned   avg;
        int unsigned   lim;
        int unsigned   m;
        int unsigned   r;
        int unsigned   g;
        int unsigned   b;
        logic          beat;
        logic          lit;
        light_result_t res;

        // Scale into a ring entry, clamping anything that would not fit 12 bits.
        quot = energy / RING_DEPTH;
        if (quot > ENTRY_MAX) begin
            quot = ENTRY_MAX;
        end
        ring_total            = ring_total - energy_ring[ring_pos] + TOTAL_W'(quot);
        energy_ring[ring_pos] = ENTRY_W'(quot);
        if (ring_pos == RING_DEPTH - 1) begin
            ring_filled = 1'b1;
        end

        beat = 1'b0;
        lit  = 1'b0;
        if (ring_filled) begin
            avg = ring_total;
            if (avg > silence_lim) begin
                lim  = avg * RATIO_NUM / RATIO_DEN + avg / RATIO_DEN2;
                beat = (energy > lim) || (energy >= saturate_lim);
                if (beat || last_beat) begin
                    // Only a fresh beat, not a continuing one or one after a hold, recolors.
                    if (!last_beat && !holding) begin
                        m = led_scale;
                        r = 0;
                        g = 0;
                        b = 0;
                        case (t_color_sel'(rnd % 7))
                            COLOR_WHITE: begin
                                r = m / 2;
                                g = m / 4;
                                b = m / 4;
                            end
                            COLOR_RED: begin
                                r = m;
                            end
                            COLOR_MAGENTA: begin
                                r = m * 2 / 3;
                                b = m / 3;
                            end
                            COLOR_BLUE: begin
                                b = m;
                            end
                            COLOR_CYAN: begin
                                g = m / 2;
                                b = m / 2;
                            end
                            COLOR_GREEN: begin
                                g = m;
                            end
                            default: begin
                                r = m * 3 / 4;
                                g = m / 4;
                            end
                        endcase
                        shown.red   = LEVEL_W'(r);
                        shown.green = LEVEL_W'(g);
                        shown.blue  = LEVEL_W'(b);
                        fresh_colors++;
                    end
                    holding   = !beat && last_beat;
                    last_beat = beat;
                    lit       = 1'b1;
                end else begin
                    shown     = '0;
                    last_beat = 1'b0;
                    holding   = 1'b0;
                end
            end else begin
                shown     = '0;
                last_beat = 1'b0;
                holding   = 1'b0;
                quiet_items++;
            end
        end
        ring_pos = (ring_pos == RING_DEPTH - 1) ? 0 : ring_pos + 1;

        if (beat) begin
            beats_predicted++;
        end
        res.history_ready = ring_filled;
        res.beat_now      = beat;
        res.light_on      = lit;
        res.levels        = shown;
        expected_results.push_back(res);
    endfunction

    // Check each result handshake first, then record register writes and new items,
    // all from values settled before this edge.
    always @(posedge clk) begin : watch_channels
        light_result_t seen;
        light_result_t want;
        item_taken = 1'b0;
        if (rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                seen.history_ready = result_ch.history_ready;
                seen.beat_now      = result_ch.beat_now;
                seen.light_on      = result_ch.light_on;
                seen.levels.red    = result_ch.red_level;
                seen.levels.green  = result_ch.green_level;
                seen.levels.blue   = result_ch.blue_level;
                results_checked++;
                if (expected_results.size() == 0) begin
                    note_failure({
                        $sformatf("result %0d arrived with nothing expected: ",
                                  results_checked),
                        $sformatf("ready=%0b beat=%0b lit=%0b rgb=%02h%02h%02h",
                                  seen.history_ready, seen.beat_now, seen.light_on,
                                  seen.levels.red, seen.levels.green, seen.levels.blue)});
                end else begin
                    want = expected_results.pop_front();
                    if (seen !== want) begin
                        note_failure({
                            $sformatf("result %0d mismatch: expected ", results_checked),
                            $sformatf("ready=%0b beat=%0b lit=%0b rgb=%02h%02h%02h",
                                      want.history_ready, want.beat_now, want.light_on,
                                      want.levels.red, want.levels.green, want.levels.blue),
                            $sformatf(", got ready=%0b beat=%0b lit=%0b rgb=%02h%02h%02h",
                                      seen.history_ready, seen.beat_now, seen.light_on,
                                      seen.levels.red, seen.levels.green, seen.levels.blue)});
                    end
                end
            end
            if (cfg_we) begin
                writes_applied++;
                case (cfg_index)
                    CFG_SILENCE_THRESHOLD: silence_lim  = cfg_wdata[SIL_W-1:0];
                    CFG_SATURATION_LEVEL:  saturate_lim = cfg_wdata[SAT_W-1:0];
                    CFG_LED_FULL_SCALE:    led_scale    = cfg_wdata[LEVEL_W-1:0];
                    default: ;  // drop writes to unused indexes
                endcase
            end
            if (item_ch.valid && item_ch.ready) begin
                predict_light(item_ch.energy_sum, item_ch.random_value);
                items_accepted++;
                item_taken = 1'b1;
            end
        end
    end

    // Item driver: bursts of random length with random gaps. Pauses and register writes
    // hold the sender until every expected result is back and the pipeline has settled.
    always @(negedge clk) begin : drive_items
        step_t head;
        logic  nxt_valid;
        logic  nxt_we;
        nxt_valid = 1'b0;
        nxt_we    = 1'b0;
        if (rst_n) begin
            if (item_ch.valid && !item_taken) begin
                // Hold the offered item until the block takes it.
                nxt_valid = 1'b1;
            end else if (stimulus.size() != 0) begin
                head = stimulus[0];
                if (head.kind == STEP_ITEM) begin
                    if (gap_left != 0) begin
                        gap_left--;
                    end else begin
                        void'(stimulus.pop_front());
                        item_ch.energy_sum   <= head.energy;
                        item_ch.random_value <= head.rnd;
                        nxt_valid = 1'b1;
                        if (burst_left > 1) begin
                            burst_left--;
                        end else begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                        end
                    end
                end else if (expected_results.size() != 0) begin
                    settle_left = SETTLE_CYCLES;
                end else if (settle_left != 0) begin
                    settle_left--;
                end else begin
                    void'(stimulus.pop_front());
                    if (head.kind == STEP_WRITE) begin
                        nxt_we = 1'b1;
                        cfg_index <= head.reg_index;
                        cfg_wdata <= head.reg_data;
                    end
                end
            end
        end
        item_ch.valid <= nxt_valid;
        cfg_we        <= nxt_we;
    end

    // Result receiver: cycles through its own stall patterns, and twice holds off for a
    // long stretch so the block fills up and pushes back on the sender.
    always @(negedge clk) begin : pace_results
        logic nxt_ready;
        rx_cycle++;
        if (hold_left != 0) begin
            hold_left--;
            nxt_ready = 1'b0;
        end else if (long_holds < 2 && results_checked >= hold_trigger) begin
            hold_left    = LONG_HOLD_CYCLES;
            long_holds++;
            hold_trigger = hold_trigger + 450;
            nxt_ready    = 1'b0;
        end else begin
            case (rx_pattern_t'((rx_cycle / 64) % 4))
                RX_STEADY:    nxt_ready = 1'b1;
                RX_LIGHT:     nxt_ready = ($urandom_range(0, 3) != 0);
                RX_ALTERNATE: nxt_ready = (rx_cycle % 2 == 0);
                default:      nxt_ready = ($urandom_range(0, 9) < 3);
            endcase
        end
        result_ch.ready <= nxt_ready;
    end

    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_results.size());
            $display("tb_audio_energy_beat_detector_unit: FAIL");
            $finish;
        end
    end

    initial begin : run_test
        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.energy_sum   = '0;
        item_ch.random_value = '0;
        result_ch.ready      = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_wdata            = '0;

        // Fill the ring at reset settings: field extremes first (no detection yet),
        // then a steady level well above the silence threshold.
        add_item(ENERGY_MAX, 2 ** RANDOM_W - 1);
        add_item(0, 0);
        for (int n = 2; n < RING_DEPTH; n++) begin
            add_item(BASE_ENERGY, $urandom);
        end
        // Every color: fresh beat, sometimes a continuing beat, one held item, then off.
        for (int c = COLOR_WHITE; c <= COLOR_YELLOW; c++) begin
            add_item(ENERGY_MAX, color_word(c));
            if (c % 2 == 0) begin
                add_item(ENERGY_MAX, color_word((c + 3) % 7));
            end
            add_item(BASE_ENERGY, $urandom);
            add_item(BASE_ENERGY, $urandom);
        end
        // A beat right after a hold keeps the red already shown.
        add_item(ENERGY_MAX, color_word(COLOR_RED));
        add_item(BASE_ENERGY, $urandom);
        add_item(ENERGY_MAX, color_word(COLOR_BLUE));
        add_item(BASE_ENERGY, $urandom);
        add_item(BASE_ENERGY, $urandom);
        add_pause();

        // Zero thresholds: every item a beat; zero full scale lights with all levels zero.
        add_write(CFG_SILENCE_THRESHOLD, 0);
        add_write(CFG_SATURATION_LEVEL, 0);
        add_write(CFG_LED_FULL_SCALE, 0);
        add_write(CFG_SPARE_INDEX, $urandom);
        add_random_items(120, 60000);

        // Top thresholds: the average can never exceed silence, so every item is quiet.
        add_write(CFG_SILENCE_THRESHOLD, 2 ** SIL_W - 1);
        add_write(CFG_SATURATION_LEVEL, 2 ** SAT_W - 1);
        add_write(CFG_LED_FULL_SCALE, 128);
        add_random_items(120, ENERGY_MAX);

        // Random mid-range settings.
        for (int p = 0; p < 4; p++) begin
            add_write(CFG_SILENCE_THRESHOLD, $urandom_range(0, 2000));
            add_write(CFG_SATURATION_LEVEL, $urandom_range(60000, ENERGY_MAX));
            add_write(CFG_LED_FULL_SCALE, $urandom_range(1, 254));
            add_random_items(150, 60000);
            add_pause();
        end

        // Back to reset values, with another dropped write to the unused index.
        add_write(CFG_SILENCE_THRESHOLD, SIL_RESET);
        add_write(CFG_SATURATION_LEVEL, SAT_RESET);
        add_write(CFG_LED_FULL_SCALE, FULL_RESET);
        add_write(CFG_SPARE_INDEX, $urandom);
        add_random_items(200, 60000);

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        while (stimulus.size() != 0 || expected_results.size() != 0 || item_ch.valid) begin
            @(negedge clk);
        end
        repeat (DRAIN_TAIL) @(negedge clk);
        if (expected_results.size() != 0) begin
            note_failure($sformatf("%0d expected results never arrived",
                                   expected_results.size()));
        end

        $display("run: %0d items in, %0d results checked, %0d register writes, %0d failures",
                 items_accepted, results_checked, writes_applied, fail_count);
        $display("seen: %0d beats, %0d fresh colors, %0d quiet items, %0d long receiver holds",
                 beats_predicted, fresh_colors, quiet_items, long_holds);
        if (fail_count == 0) begin
            $display("tb_audio_energy_beat_detector_unit: PASS");
        end else begin
            $display("tb_audio_energy_beat_detector_unit: FAIL");
        end
        $finish;
    end

endmodule
